@@ src/shst_pkg.sv @@
// shared types and constants of the scoped hash symbol table
package shst_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ENTER  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_POP    = 2'd2
   } shst_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOT_FOUND = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_ZERO_KEY  = 3'd4
   } shst_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP_READ,
      ST_HASH,
      ST_HEAD,
      ST_WALK
   } shst_state_type;

endpackage

@@ src/shst_ram.sv @@
// generic single port ram with registered read
module shst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/shst_mod.sv @@
// residue of a key by a constant modulus: reciprocal multiply, then multiply back
module shst_mod #(
   parameter int KEY_W   = 32,
   parameter int MODULUS = 127
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_W-1:0]           key,
   output logic                       done,
   output logic [$clog2(MODULUS)-1:0] residue
);

   localparam int RW    = $clog2(MODULUS);
   localparam int SHIFT = KEY_W + RW;
   localparam int PW    = 2 * KEY_W + 1;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(MODULUS - 1)) / 64'(MODULUS);
   localparam logic [KEY_W:0]   RECIP = RECIP_FULL[KEY_W:0];
   localparam logic [KEY_W-1:0] MODK  = KEY_W'(MODULUS);

   logic             mul_ff, mul_in;
   logic             back_ff, back_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] quot_ff, quot_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [PW-1:0]    prod;
   logic [KEY_W-1:0] diff;

   // quotient is exact for every key below 2**KEY_W
   always_comb begin
      prod = PW'(key_ff) * PW'(RECIP);
      diff = key_ff - quot_ff * MODK;
   end

   always_comb begin
      mul_in  = start;
      back_in = mul_ff;
      done_in = back_ff;
      key_in  = key_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         key_in = key;
      end
      if (mul_ff) begin
         quot_in = KEY_W'(prod >> SHIFT);
      end
      if (back_ff) begin
         rem_in = RW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         back_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         back_ff <= back_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done    = done_ff;
   assign residue = rem_ff;

endmodule

@@ src/scoped_hash_symbol_table_unit.sv @@
// top level of the scoped hash symbol table
//
// request channel: a transaction is taken at a rising edge with start high and
// busy low; req_op selects enter (0), look up (1) or pop newest (2), with
// req_key and req_value sampled at that edge. op 3 answers ok with zero data.
// response channel: every transaction gives exactly one response, shown for one
// cycle with rsp_valid high; the receiver cannot stall it.
// the bucket index is the key modulo BUCKETS, worked out by a residue unit:
// a reciprocal multiply for the quotient, then a multiply back.
// busy drops in the cycle rsp_valid is shown, so the next transaction may be
// taken then; no new transaction is taken until the last one is answered.
// after reset the bucket heads are cleared by a pass over all BUCKETS heads,
// during which busy stays high.
module scoped_hash_symbol_table_unit #(
   parameter int BUCKETS      = 127,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_BITS     = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [shst_pkg::OP_W-1:0]     req_op,
   input  logic [shst_pkg::DATA_W-1:0]   req_key,
   input  logic [shst_pkg::DATA_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [shst_pkg::STATUS_W-1:0] rsp_status,
   output logic [shst_pkg::DATA_W-1:0]   rsp_result_key,
   output logic [shst_pkg::DATA_W-1:0]   rsp_result_value
);

   import shst_pkg::*;

   localparam int KW  = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
   localparam int BIW = $clog2(BUCKETS);
   localparam int CW  = $clog2(POOL_ENTRIES + 1);
   localparam int SW  = $clog2(POOL_ENTRIES);
   localparam int EW  = KW + DATA_W + CW;

   shst_state_type state_ff, state_in;
   shst_op_type    op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CW-1:0]     link_ff, link_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [BIW-1:0]    clr_ff, clr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   shst_status_type      rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;

   logic             hash_start;
   logic [KW-1:0]    hash_key;
   logic             hash_done;
   logic [BIW-1:0]   residue;

   logic             head_we;
   logic [BIW-1:0]   head_addr;
   logic [CW-1:0]    head_wdata;
   logic [CW-1:0]    head_rd;

   logic             ent_we;
   logic [SW-1:0]    ent_addr;
   logic [EW-1:0]    ent_wdata;
   logic [EW-1:0]    ent_rd;
   logic [KW-1:0]    ent_key_rd;
   logic [DATA_W-1:0] ent_value_rd;
   logic [CW-1:0]    ent_next_rd;

   logic [CW-1:0]    link_cur;
   logic [CW-1:0]    link_m1;
   logic [CW-1:0]    count_m1;
   logic             link_end;
   logic [KW-1:0]    req_key_k;

   assign ent_key_rd   = ent_rd[EW-1 -: KW];
   assign ent_value_rd = ent_rd[CW +: DATA_W];
   assign ent_next_rd  = ent_rd[CW-1:0];
   assign req_key_k    = req_key[KW-1:0];

   assign link_cur = (state_ff == ST_HEAD) ? head_rd : ent_next_rd;
   assign link_m1  = link_cur - CW'(1);
   assign count_m1 = count_ff - CW'(1);
   assign link_end = (link_cur == '0) || (link_cur > count_ff);

   shst_mod #(
      .KEY_W   (KW),
      .MODULUS (BUCKETS)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (hash_key),
      .done    (hash_done),
      .residue (residue)
   );

   shst_ram #(
      .WIDTH (CW),
      .DEPTH (BUCKETS)
   ) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .addr  (head_addr),
      .wdata (head_wdata),
      .rdata (head_rd)
   );

   shst_ram #(
      .WIDTH (EW),
      .DEPTH (POOL_ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .addr  (ent_addr),
      .wdata (ent_wdata),
      .rdata (ent_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      link_ff       <= link_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      link_in       = link_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      hash_start    = 1'b0;
      hash_key      = key_ff;
      head_we       = 1'b0;
      head_addr     = residue;
      head_wdata    = link_ff;
      ent_we        = 1'b0;
      ent_addr      = count_m1[SW-1:0];
      ent_wdata     = {key_ff, value_ff, head_rd};

      case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_addr  = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + BIW'(1);
            if (clr_ff == BIW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in         = shst_op_type'(req_op);
               key_in        = req_key_k;
               value_in      = req_value;
               rsp_status_in = STATUS_OK;
               rsp_key_in    = '0;
               rsp_value_in  = '0;
               case (req_op)
                  OP_ENTER: begin
                     if (req_key_k == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_ZERO_KEY;
                     end else if (count_ff == CW'(POOL_ENTRIES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        hash_start = 1'b1;
                        hash_key   = req_key_k;
                        state_in   = ST_HASH;
                     end
                  end
                  OP_LOOKUP: begin
                     if (req_key_k == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_ZERO_KEY;
                     end else begin
                        hash_start = 1'b1;
                        hash_key   = req_key_k;
                        state_in   = ST_HASH;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_READ: begin
            key_in     = ent_key_rd;
            value_in   = ent_value_rd;
            link_in    = ent_next_rd;
            hash_start = 1'b1;
            hash_key   = ent_key_rd;
            state_in   = ST_HASH;
         end
         ST_HASH: begin
            if (hash_done) begin
               if (op_ff == OP_POP) begin
                  head_we       = 1'b1;
                  head_wdata    = link_ff;
                  count_in      = count_m1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_key_in    = DATA_W'(key_ff);
                  rsp_value_in  = value_ff;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (op_ff == OP_ENTER) begin
               ent_we        = 1'b1;
               ent_addr      = count_ff[SW-1:0];
               head_we       = 1'b1;
               head_wdata    = count_ff + CW'(1);
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else if (link_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end else begin
               ent_addr = link_m1[SW-1:0];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ent_key_rd == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = ent_value_rd;
               state_in      = ST_IDLE;
            end else if (link_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end else begin
               ent_addr = link_m1[SW-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_key   = rsp_key_ff;
   assign rsp_result_value = rsp_value_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(POOL_ENTRIES))
      else $error("entry count beyond pool size");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   a_enter_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEAD && op_ff == OP_ENTER) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("enter did not advance entry count");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && busy))
      else $error("response or ready during clearing pass");

   a_hash_done_state: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("residue finished outside hash wait");
`endif

endmodule

@@ sim/shst_tb_pkg.sv @@
// scoreboard for the scoped hash symbol table testbench: predictor and response checking
`timescale 1ns / 100ps
package shst_tb_pkg;
   import shst_pkg::*;

   localparam int unsigned TABLE_BUCKETS = 127;
   localparam int unsigned TABLE_SLOTS   = 256;
   localparam int unsigned REPORT_LIMIT  = 10;

   // op code with no function, answered ok with zero data
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   key;
      logic [DATA_W-1:0]   value;
   } shst_response_type;

   class shst_scoreboard;
      logic [8:0]        bucket_head [TABLE_BUCKETS];
      logic [DATA_W-1:0] entry_key   [TABLE_SLOTS];
      logic [DATA_W-1:0] entry_value [TABLE_SLOTS];
      logic [8:0]        entry_next  [TABLE_SLOTS];
      int unsigned       entry_count;
      shst_response_type expected_responses [$];
      int unsigned       failures;

      function new();
         foreach (bucket_head[i]) bucket_head[i] = '0;
         foreach (entry_key[i]) begin
            entry_key[i]   = '0;
            entry_value[i] = '0;
            entry_next[i]  = '0;
         end
         entry_count = 0;
         failures    = 0;
      endfunction

      function shst_response_type predict_response(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] key,
                                                   logic [DATA_W-1:0] value);
         shst_response_type resp;
         int unsigned       bucket;
         int unsigned       link;
         int unsigned       slot;
         resp.status = STATUS_OK;
         resp.key    = '0;
         resp.value  = '0;
         case (op)
            OP_ENTER: begin
               if (key == '0) begin
                  resp.status = STATUS_ZERO_KEY;
               end else if (entry_count >= TABLE_SLOTS) begin
                  resp.status = STATUS_FULL;
               end else begin
                  bucket = key % TABLE_BUCKETS;
                  entry_key[entry_count]   = key;
                  entry_value[entry_count] = value;
                  entry_next[entry_count]  = bucket_head[bucket];
                  bucket_head[bucket]      = 9'(entry_count + 1);
                  entry_count++;
               end
            end
            OP_LOOKUP: begin
               if (key == '0) begin
                  resp.status = STATUS_ZERO_KEY;
               end else begin
                  resp.status = STATUS_NOT_FOUND;
                  link = bucket_head[key % TABLE_BUCKETS];
                  for (int unsigned steps = 0; steps < TABLE_SLOTS; steps++) begin
                     if (link == 0 || link > entry_count) break;
                     slot = link - 1;
                     if (entry_key[slot] == key) begin
                        resp.status = STATUS_OK;
                        resp.value  = entry_value[slot];
                        break;
                     end
                     link = entry_next[slot];
                  end
               end
            end
            OP_POP: begin
               if (entry_count == 0) begin
                  resp.status = STATUS_EMPTY;
               end else begin
                  slot = entry_count - 1;
                  bucket_head[entry_key[slot] % TABLE_BUCKETS] = entry_next[slot];
                  entry_count = slot;
                  resp.key    = entry_key[slot];
                  resp.value  = entry_value[slot];
               end
            end
            default: ;
         endcase
         return resp;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] key,
                                 logic [DATA_W-1:0] value);
         expected_responses.push_back(predict_response(op, key, value));
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] key,
                                   logic [DATA_W-1:0] value);
         shst_response_type want;
         if (expected_responses.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected response: status %0d key %h value %h", status, key, value);
            return;
         end
         want = expected_responses.pop_front();
         if (status !== want.status || key !== want.key || value !== want.value) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch: expected status %0d key %h value %h, ",
                         "got status %0d key %h value %h"},
                        want.status, want.key, want.value, status, key, value);
         end
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction
   endclass

endpackage

@@ sim/scoped_hash_symbol_table_unit_tb.sv @@
// testbench top of the scoped hash symbol table: directed and random request traffic
`timescale 1ns / 100ps
module scoped_hash_symbol_table_unit_tb;
   import shst_pkg::*;
   import shst_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 400;

   typedef enum int {
      MODE_MIXED,
      MODE_FILL,
      MODE_DRAIN
   } traffic_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [DATA_W-1:0]   req_key = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_result_key;
   logic [DATA_W-1:0]   rsp_result_value;

   shst_scoreboard table_board = new();
   bit             idle_enabled = 1'b1;
   int unsigned    cycle_count = 0;

   scoped_hash_symbol_table_unit #(
      .BUCKETS      (TABLE_BUCKETS),
      .POOL_ENTRIES (TABLE_SLOTS),
      .KEY_BITS     (32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_key   (rsp_result_key),
      .rsp_result_value (rsp_result_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scoped_hash_symbol_table_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         table_board.check_response(rsp_status, rsp_result_key, rsp_result_value);
   end

   // called at a falling edge, returns at a falling edge
   // idle cycles are counted only once the block is ready again
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] value);
      int unsigned gap;
      gap = 0;
      if (idle_enabled) begin
         while ($urandom_range(0, 99) < 25) gap++;
         if ($urandom_range(0, 19) == 0) gap += $urandom_range(0, 20);
      end
      if (busy || gap != 0) begin
         start <= 1'b0;
         while (busy) @(negedge clock);
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      table_board.note_request(op, key, value);
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] colliding_key();
      return DATA_W'($urandom_range(0, 7) * TABLE_BUCKETS + $urandom_range(0, 2));
   endfunction

   function automatic logic [DATA_W-1:0] stored_key();
      if (table_board.entry_count == 0) return colliding_key();
      return table_board.entry_key[$urandom_range(0, table_board.entry_count - 1)];
   endfunction

   function automatic logic [DATA_W-1:0] any_key();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return colliding_key();
      if (pick < 75) return stored_key();
      return $urandom();
   endfunction

   task automatic send_random(input traffic_mode_type mode);
      int unsigned     pick;
      int unsigned     enter_share;
      int unsigned     lookup_share;
      logic [OP_W-1:0] op;
      logic [DATA_W-1:0] key;
      pick = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            enter_share  = 85;
            lookup_share = 95;
         end
         MODE_DRAIN: begin
            enter_share  = 3;
            lookup_share = 18;
         end
         default: begin
            enter_share  = 40;
            lookup_share = 75;
         end
      endcase
      key = any_key();
      if (pick < enter_share) op = OP_ENTER;
      else if (pick < lookup_share) op = OP_LOOKUP;
      else if ($urandom_range(0, 9) < 8) op = OP_POP;
      else if ($urandom_range(0, 1) == 0) op = OP_RESERVED;
      else begin
         op  = $urandom_range(0, 1) ? OP_ENTER : OP_LOOKUP;
         key = '0;
      end
      if (op == OP_POP || op == OP_RESERVED) key = $urandom();
      send_request(op, key, $urandom());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // error cases on an empty table
      send_request(OP_POP, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_ENTER, 32'h0000_0000, 32'hDEAD_BEEF);
      send_request(OP_LOOKUP, 32'h0000_0005, 32'h0000_0000);
      // extremes and a shared bucket
      send_request(OP_ENTER, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_ENTER, 32'h0000_0001, 32'hFFFF_FFFF);
      send_request(OP_ENTER, 32'h0000_0080, 32'h1234_5678);
      send_request(OP_LOOKUP, 32'h0000_0001, $urandom());
      send_request(OP_LOOKUP, 32'h0000_0080, $urandom());
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, $urandom());
      send_request(OP_LOOKUP, 32'h0000_00FF, $urandom());
      // shadowing and undo
      send_request(OP_ENTER, 32'h0000_0001, 32'hA5A5_A5A5);
      send_request(OP_LOOKUP, 32'h0000_0001, $urandom());
      send_request(OP_RESERVED, $urandom(), $urandom());
      send_request(OP_POP, $urandom(), $urandom());
      send_request(OP_LOOKUP, 32'h0000_0001, $urandom());
      repeat (4) send_request(OP_POP, $urandom(), $urandom());
      send_request(OP_LOOKUP, 32'h0000_0001, $urandom());
      send_request(OP_ENTER, 32'h8000_0000, 32'h0000_0001);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);

      repeat (200) send_random(MODE_MIXED);

      // long stretch without gaps while the pool fills up
      idle_enabled = 1'b0;
      while (table_board.entry_count < TABLE_SLOTS) send_random(MODE_FILL);
      repeat (4) send_request(OP_ENTER, any_key() | 32'h1, $urandom());
      repeat (4) send_request(OP_LOOKUP, stored_key(), $urandom());
      idle_enabled = 1'b1;

      while (table_board.entry_count > 0) send_random(MODE_DRAIN);
      repeat (3) send_request(OP_POP, $urandom(), $urandom());

      repeat (120) send_random(MODE_MIXED);

      start <= 1'b0;
      while (table_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_board.failures == 0 && table_board.pending() == 0) begin
         $display("scoped_hash_symbol_table_unit regression: pass");
      end else begin
         $display("scoped_hash_symbol_table_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/shst_pkg.sv
src/shst_ram.sv
src/shst_mod.sv
src/scoped_hash_symbol_table_unit.sv
sim/shst_tb_pkg.sv
sim/scoped_hash_symbol_table_unit_tb.sv
